@@ hw/rtl/aes128_key_expansion_macros.svh @@
// Assertion macros used by the key expansion module.
`ifndef AES128_KEY_EXPANSION_MACROS_SVH
`define AES128_KEY_EXPANSION_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define AKE_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// Checks that a signal holds its value into the next cycle under a condition.
`define AKE_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("value changed while held");

`endif

@@ hw/rtl/ake_pkg.sv @@
// Package with the word types, S-box and round constants of the key expansion.
package ake_pkg;

	localparam int unsigned NumRounds = 11;
	localparam int unsigned LastRound = 10;

	typedef struct packed {
		logic [63:0] key_upper;
		logic [63:0] key_lower;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  round_number;
		logic [63:0] round_key_upper;
		logic [63:0] round_key_lower;
		logic        last_round;
	} out_word_t;

	// Control passed from the sequencer into the row of column cells.
	typedef struct packed {
		logic       load;
		logic       step;
		logic [7:0] rcon;
	} cell_ctrl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] tbl [256];
		tbl = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tbl[a];
	endfunction

	// Round constant that goes into the key of round n (n = 1..10).
	function automatic logic [7:0] rcon(input logic [3:0] n);
		logic [7:0] r;
		case (n)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/ake_cell.sv @@
// One column cell of the key register: holds a 32-bit word and chains its result onward.
module ake_cell (
	input  logic               clk,
	input  ake_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]        load_word,
	input  logic [31:0]        chain_in,
	output logic [31:0]        chain_out,
	output logic [31:0]        word
);

	logic [31:0] word_q;

	// The new word is the old word XOR the new word of the column to the left.
	assign chain_out = word_q ^ chain_in;
	assign word      = word_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= load_word;
		end else if (ctrl.step) begin
			word_q <= chain_out;
		end
	end

endmodule

@@ hw/rtl/aes128_key_expansion.sv @@
// Usage: one 128-bit cipher key word goes in on in_*; eleven round-key words
// come out on out_*, rounds 0 to 10 in order, last_round set on round 10.
// Cipher key byte 4r+c is row r of key column c; round key bytes are column-major.
// The key is taken when in_valid is high and in_stall low, and only while the
// block is idle. Round 0 is registered and shown in the cycle after acceptance;
// each later round is computed by the shared round function (four S-box lookups
// feeding a row of four column cells). The busy flag drops when round 10 is
// taken, so the next key is accepted only after that edge. A stall on the output
// holds the current round key in the output register and freezes the cells.
// Reset clears the busy and valid flags; the key registers need no reset.
`include "aes128_key_expansion_macros.svh"
module aes128_key_expansion (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ake_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ake_pkg::out_word_t out_data
);

	logic                busy_q;
	logic [3:0]          round_q;
	logic                out_valid_q;
	ake_pkg::out_word_t  out_q;
	ake_pkg::cell_ctrl_t ctrl;
	logic [31:0]         load_w [4];
	logic [31:0]         cur_w [4];
	logic [31:0]         chain [5];
	logic [31:0]         subw;
	logic                accept, advance;

	assign in_stall  = busy_q;
	assign accept    = in_valid && !busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	// Advance one round once the previous result has been taken.
	assign advance   = busy_q && (!out_valid_q || !out_stall) &&
		(round_q != 4'(ake_pkg::LastRound));

	// Column words of the cipher key: key byte 4r+c lands in row r of column c.
	assign load_w[0] = {in_data.key_upper[63:56], in_data.key_upper[31:24],
		in_data.key_lower[63:56], in_data.key_lower[31:24]};
	assign load_w[1] = {in_data.key_upper[55:48], in_data.key_upper[23:16],
		in_data.key_lower[55:48], in_data.key_lower[23:16]};
	assign load_w[2] = {in_data.key_upper[47:40], in_data.key_upper[15:8],
		in_data.key_lower[47:40], in_data.key_lower[15:8]};
	assign load_w[3] = {in_data.key_upper[39:32], in_data.key_upper[7:0],
		in_data.key_lower[39:32], in_data.key_lower[7:0]};

	// Round function: rotate, substitute and add the round constant.
	always_comb begin
		subw = {ake_pkg::sbox(cur_w[3][23:16]) ^ ctrl.rcon, ake_pkg::sbox(cur_w[3][15:8]),
			ake_pkg::sbox(cur_w[3][7:0]), ake_pkg::sbox(cur_w[3][31:24])};
	end

	assign ctrl.load = accept;
	assign ctrl.step = advance;
	assign ctrl.rcon = ake_pkg::rcon(round_q + 4'd1);
	assign chain[0]  = subw;

	// Row of four column cells.
	for (genvar g = 0; g < 4; g++) begin : g_cell
		ake_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.load_word(load_w[g]),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.word     (cur_w[g])
		);
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q      <= 1'b1;
				round_q     <= '0;
				out_valid_q <= 1'b1;
			end else if (advance) begin
				round_q     <= round_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
				if (round_q == 4'(ake_pkg::LastRound)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= '{4'd0, {load_w[0], load_w[1]}, {load_w[2], load_w[3]}, 1'b0};
		end else if (advance) begin
			out_q <= '{round_q + 4'd1, {chain[1], chain[2]}, {chain[3], chain[4]},
				(round_q + 4'd1) == 4'(ake_pkg::LastRound)};
		end
	end

	`AKE_ASSERT_IMP(a_valid_busy, clk, arst_n, out_valid_q, busy_q)
	`AKE_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_q)
	`AKE_ASSERT_IMP(a_round_range, clk, arst_n, busy_q, round_q <= 4'(ake_pkg::LastRound))
	`AKE_ASSERT_IMP(a_last_flag, clk, arst_n, out_valid_q,
		out_q.last_round == (out_q.round_number == 4'(ake_pkg::LastRound)))

endmodule
